FILE: design/c3wfk_pkg.sv
package c3wfk_pkg;

	localparam int unsigned IMAGE_SIZE_DEF = 1024;
	localparam int unsigned COORD_W        = 10;
	localparam int unsigned PIXEL_W        = 8;
	localparam int unsigned VALUE_W        = 13;
	localparam int unsigned SEL_W          = 3;
	localparam int unsigned WEIGHT_W       = 4;
	localparam int unsigned KERNEL_COUNT   = 5;
	localparam int unsigned QUEUE_DEPTH    = 4;
	localparam int unsigned CFG_ADDR_W     = 3;
	localparam int unsigned CFG_DATA_W     = 32;

	localparam logic [0:0] REG_KERNEL_SELECT = 1'b0;

	typedef enum logic {
		KIND_LOAD    = 1'b0,
		KIND_COMPUTE = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_LAST,
		BK_EMIT
	} back_state_t;

	typedef struct packed {
		kind_t                kind;
		logic [COORD_W-1:0]   row_in;
		logic [COORD_W-1:0]   col_in;
		logic [COORD_W-1:0]   r;
		logic [COORD_W-1:0]   c;
		logic [PIXEL_W-1:0]   pixel;
	} job_t;

	typedef logic signed [WEIGHT_W-1:0] weight_t;

	localparam weight_t KERNEL_TAB [KERNEL_COUNT][3][3] = '{
		'{'{ 4'sd0, -4'sd1,  4'sd0}, '{-4'sd1,  4'sd5,  4'sd1}, '{ 4'sd0, -4'sd1,  4'sd0}},
		'{'{ 4'sd0,  4'sd0,  4'sd0}, '{-4'sd1,  4'sd1,  4'sd0}, '{ 4'sd0,  4'sd0,  4'sd0}},
		'{'{ 4'sd0,  4'sd1,  4'sd0}, '{ 4'sd1, -4'sd4,  4'sd1}, '{ 4'sd0,  4'sd1,  4'sd0}},
		'{'{-4'sd1,  4'sd0,  4'sd1}, '{-4'sd2,  4'sd0,  4'sd2}, '{-4'sd1,  4'sd0,  4'sd1}},
		'{'{ 4'sd1, -4'sd2,  4'sd1}, '{-4'sd2,  4'sd5, -4'sd2}, '{ 4'sd1, -4'sd2,  4'sd1}}
	};

	// codes above the last kernel fall back to sharpen
	function automatic weight_t kernel_weight(logic [SEL_W-1:0] sel, logic [1:0] a,
			logic [1:0] b);
		logic [SEL_W-1:0] s;
		weight_t          w;
		s = (sel > SEL_W'(KERNEL_COUNT - 1)) ? SEL_W'(KERNEL_COUNT - 1) : sel;
		w = '0;
		if (a != 2'd3 && b != 2'd3) begin
			w = KERNEL_TAB[s][a][b];
		end
		return w;
	endfunction

endpackage

FILE: design/c3wfk_if.sv
interface c3wfk_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [0:0]                           kind;
	logic [c3wfk_pkg::COORD_W-1:0]        row;
	logic [c3wfk_pkg::COORD_W-1:0]        col;
	logic [c3wfk_pkg::PIXEL_W-1:0]        pixel;

	modport source (output valid, kind, row, col, pixel, input ready);
	modport sink   (input valid, kind, row, col, pixel, output ready);
endinterface

interface c3wfk_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [c3wfk_pkg::VALUE_W-1:0] value;
	logic [c3wfk_pkg::COORD_W-1:0]        out_row;
	logic [c3wfk_pkg::COORD_W-1:0]        out_col;

	modport source (output valid, value, out_row, out_col, input ready);
	modport sink   (input valid, value, out_row, out_col, output ready);
endinterface

FILE: design/c3wfk_front.sv
module c3wfk_front #(
	parameter int unsigned IMAGE_SIZE = c3wfk_pkg::IMAGE_SIZE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	c3wfk_req_if.sink         req,
	output c3wfk_pkg::job_t   push_job,
	output logic              push_valid,
	input  logic              push_ready
);

	localparam int unsigned CW          = c3wfk_pkg::COORD_W;
	localparam int unsigned RECIP_SHIFT = 20;
	localparam int unsigned RECIP       = (1 << RECIP_SHIFT) / IMAGE_SIZE;
	localparam int unsigned PROD_W      = 32;
	localparam int unsigned DIFF_W      = 24;

	logic                  v_s1;
	c3wfk_pkg::job_t       job_s1;
	logic [CW-1:0]         qr_s1;
	logic [CW-1:0]         qc_s1;
	logic                  advance;
	logic [PROD_W-1:0]     prod_r;
	logic [PROD_W-1:0]     prod_c;

	// remainder from an estimated quotient that may be one short
	function automatic logic [CW-1:0] wrap_coord(logic [CW-1:0] v, logic [CW-1:0] q);
		logic [DIFF_W-1:0] diff;
		diff = DIFF_W'(v) - DIFF_W'(q) * DIFF_W'(IMAGE_SIZE);
		if (diff >= DIFF_W'(IMAGE_SIZE)) begin
			diff = diff - DIFF_W'(IMAGE_SIZE);
		end
		return diff[CW-1:0];
	endfunction

	assign advance   = !v_s1 || push_ready;
	assign req.ready = advance;

	assign prod_r = PROD_W'(req.row) * PROD_W'(RECIP);
	assign prod_c = PROD_W'(req.col) * PROD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && req.valid) begin
			job_s1.kind   <= c3wfk_pkg::kind_t'(req.kind);
			job_s1.row_in <= req.row;
			job_s1.col_in <= req.col;
			job_s1.r      <= '0;
			job_s1.c      <= '0;
			job_s1.pixel  <= req.pixel;
			qr_s1         <= CW'(prod_r >> RECIP_SHIFT);
			qc_s1         <= CW'(prod_c >> RECIP_SHIFT);
		end
	end

	always_comb begin
		push_job   = job_s1;
		push_job.r = wrap_coord(job_s1.row_in, qr_s1);
		push_job.c = wrap_coord(job_s1.col_in, qc_s1);
	end

	assign push_valid = v_s1;

endmodule

FILE: design/c3wfk_queue.sv
module c3wfk_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  c3wfk_pkg::job_t   push_job,
	input  logic              push_valid,
	output logic              push_ready,
	output c3wfk_pkg::job_t   pop_job,
	output logic              pop_valid,
	input  logic              pop_ready
);

	localparam int unsigned DEPTH = c3wfk_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	c3wfk_pkg::job_t   slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

FILE: design/c3wfk_back.sv
module c3wfk_back #(
	parameter int unsigned IMAGE_SIZE = c3wfk_pkg::IMAGE_SIZE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [c3wfk_pkg::SEL_W-1:0]      kernel_select,
	input  c3wfk_pkg::job_t                  pop_job,
	input  logic                             pop_valid,
	output logic                             pop_ready,
	c3wfk_rsp_if.source                      rsp
);

	localparam int unsigned IDX_W  = $clog2(IMAGE_SIZE);
	localparam int unsigned ADDR_W = $clog2(IMAGE_SIZE * IMAGE_SIZE);
	localparam int unsigned VW     = c3wfk_pkg::VALUE_W;
	localparam int unsigned PW     = c3wfk_pkg::PIXEL_W;
	localparam int unsigned CW     = c3wfk_pkg::COORD_W;

	logic [PW-1:0]              mem [IMAGE_SIZE * IMAGE_SIZE];
	logic [PW-1:0]              rd_q;

	c3wfk_pkg::back_state_t     st_q;
	c3wfk_pkg::back_state_t     st_d;
	c3wfk_pkg::job_t            job_q;
	logic [c3wfk_pkg::SEL_W-1:0] sel_q;
	logic [1:0]                 a_q;
	logic [1:0]                 b_q;
	logic signed [VW-1:0]       acc_q;
	logic                       tap_v_s1;
	c3wfk_pkg::weight_t         w_s1;

	logic                       out_v_q;
	logic signed [VW-1:0]       out_value_q;
	logic [CW-1:0]              out_row_q;
	logic [CW-1:0]              out_col_q;

	logic                       start;
	logic                       mem_we;
	logic                       emit;
	logic [IDX_W-1:0]           r_idx;
	logic [IDX_W-1:0]           c_idx;
	logic [IDX_W-1:0]           row_sel;
	logic [IDX_W-1:0]           col_sel;
	logic [ADDR_W-1:0]          mem_addr;
	logic signed [VW-1:0]       pix_ext;
	logic signed [VW-1:0]       w_ext;
	logic signed [VW-1:0]       prod;

	assign start = pop_valid && pop_ready && (pop_job.kind == c3wfk_pkg::KIND_COMPUTE);

	always_comb begin
		st_d = st_q;
		case (st_q)
			c3wfk_pkg::BK_IDLE: begin
				if (start) begin
					st_d = c3wfk_pkg::BK_READ;
				end
			end
			c3wfk_pkg::BK_READ: begin
				if (a_q == 2'd2 && b_q == 2'd2) begin
					st_d = c3wfk_pkg::BK_LAST;
				end
			end
			c3wfk_pkg::BK_LAST: st_d = c3wfk_pkg::BK_EMIT;
			c3wfk_pkg::BK_EMIT: begin
				if (!out_v_q || rsp.ready) begin
					st_d = c3wfk_pkg::BK_IDLE;
				end
			end
			default: st_d = c3wfk_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop_ready = 1'b0;
		mem_we    = 1'b0;
		emit      = 1'b0;
		case (st_q)
			c3wfk_pkg::BK_IDLE: begin
				pop_ready = 1'b1;
				mem_we    = pop_valid && (pop_job.kind == c3wfk_pkg::KIND_LOAD);
			end
			c3wfk_pkg::BK_EMIT: emit = !out_v_q || rsp.ready;
			default: ;
		endcase
	end

	// toroidal neighbours of the window centre
	assign r_idx = IDX_W'(job_q.r);
	assign c_idx = IDX_W'(job_q.c);

	always_comb begin
		case (a_q)
			2'd0:    row_sel = (r_idx == '0) ? IDX_W'(IMAGE_SIZE - 1) : r_idx - 1'b1;
			2'd1:    row_sel = r_idx;
			default: row_sel = (r_idx == IDX_W'(IMAGE_SIZE - 1)) ? '0 : r_idx + 1'b1;
		endcase
		case (b_q)
			2'd0:    col_sel = (c_idx == '0) ? IDX_W'(IMAGE_SIZE - 1) : c_idx - 1'b1;
			2'd1:    col_sel = c_idx;
			default: col_sel = (c_idx == IDX_W'(IMAGE_SIZE - 1)) ? '0 : c_idx + 1'b1;
		endcase
		if (st_q == c3wfk_pkg::BK_IDLE) begin
			mem_addr = ADDR_W'(IDX_W'(pop_job.r)) * ADDR_W'(IMAGE_SIZE)
				+ ADDR_W'(IDX_W'(pop_job.c));
		end else begin
			mem_addr = ADDR_W'(row_sel) * ADDR_W'(IMAGE_SIZE) + ADDR_W'(col_sel);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= pop_job.pixel;
		end
		rd_q <= mem[mem_addr];
	end

	assign pix_ext = VW'($signed({1'b0, rd_q}));
	assign w_ext   = VW'(w_s1);
	assign prod    = pix_ext * w_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= c3wfk_pkg::BK_IDLE;
			a_q      <= '0;
			b_q      <= '0;
			tap_v_s1 <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			st_q     <= st_d;
			tap_v_s1 <= (st_q == c3wfk_pkg::BK_READ);
			if (start) begin
				a_q <= '0;
				b_q <= '0;
			end else if (st_q == c3wfk_pkg::BK_READ) begin
				if (b_q == 2'd2) begin
					b_q <= '0;
					a_q <= a_q + 1'b1;
				end else begin
					b_q <= b_q + 1'b1;
				end
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			job_q <= pop_job;
			sel_q <= kernel_select;
			acc_q <= '0;
		end else if (tap_v_s1) begin
			acc_q <= acc_q + prod;
		end
		w_s1 <= c3wfk_pkg::kernel_weight(sel_q, a_q, b_q);
		if (emit) begin
			out_value_q <= acc_q;
			out_row_q   <= job_q.row_in;
			out_col_q   <= job_q.col_in;
		end
	end

	assign rsp.valid   = out_v_q;
	assign rsp.value   = out_value_q;
	assign rsp.out_row = out_row_q;
	assign rsp.out_col = out_col_q;

endmodule

FILE: design/conv3x3_wrap_fixed_kernels_unit.sv
// 3x3 convolution over a square 8-bit frame store with wrap-around edges.
// req carries transactions of kind, row, col and pixel. A load (kind 0)
// writes pixel at (row, col) and gives no result; a compute (kind 1) gives
// one transaction on rsp with the signed weighted window sum and the
// centre coordinates echoed unchanged. Coordinates beyond the image wrap.
// The APB port holds kernel_select at address 0 (focus 0, edge enhance 1,
// edge detect 2, sobel 3, sharpen 4; higher codes act as sharpen); write it
// only while the block is idle.
// Front end: reduces coordinates into a register; a four-entry queue follows.
// Back end: a load is one write to the single-port frame memory; a compute
// pops the job, makes nine reads on that port, waits out the read latency
// and then fills the output register. A request passes the front-end
// register, the queue and the back end sequencer before rsp.valid rises.
// Loads go one per cycle while the back end is idle; none during a compute.
// Reset clears the queue, the sequencer and kernel_select; the frame store
// is not cleared and must be written before it is read.
// A stalled rsp holds its transaction; the back end stops at the next
// result and the queue and front end fill, then req.ready drops.
module conv3x3_wrap_fixed_kernels_unit #(
	parameter int unsigned IMAGE_SIZE = c3wfk_pkg::IMAGE_SIZE_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	c3wfk_req_if.sink                             req,
	c3wfk_rsp_if.source                           rsp,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [c3wfk_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [c3wfk_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [c3wfk_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                  pready
);

	localparam int unsigned SW = c3wfk_pkg::SEL_W;

	logic [SW-1:0]      kernel_select_q;
	c3wfk_pkg::job_t    push_job;
	logic               push_valid;
	logic               push_ready;
	c3wfk_pkg::job_t    pop_job;
	logic               pop_valid;
	logic               pop_ready;
	logic               reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[c3wfk_pkg::CFG_ADDR_W-1] == c3wfk_pkg::REG_KERNEL_SELECT);
	assign prdata  = reg_hit ? c3wfk_pkg::CFG_DATA_W'(kernel_select_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_select_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			kernel_select_q <= pwdata[SW-1:0];
		end
	end

	c3wfk_front #(.IMAGE_SIZE(IMAGE_SIZE)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_job   (push_job),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	c3wfk_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_job   (push_job),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_job    (pop_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	c3wfk_back #(.IMAGE_SIZE(IMAGE_SIZE)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.kernel_select (kernel_select_q),
		.pop_job       (pop_job),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.rsp           (rsp)
	);

endmodule

FILE: sim/conv3x3_wrap_fixed_kernels_unit_tb.sv
module conv3x3_wrap_fixed_kernels_unit_tb;

	localparam int COORD_W      = c3wfk_pkg::COORD_W;
	localparam int PIXEL_W      = c3wfk_pkg::PIXEL_W;
	localparam int VALUE_W      = c3wfk_pkg::VALUE_W;
	localparam int SEL_W        = c3wfk_pkg::SEL_W;
	localparam int KERNEL_COUNT = c3wfk_pkg::KERNEL_COUNT;
	localparam int CFG_ADDR_W   = c3wfk_pkg::CFG_ADDR_W;
	localparam int CFG_DATA_W   = c3wfk_pkg::CFG_DATA_W;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASE_OPS     = 220;
	localparam int PHASE_COUNT   = 8;
	localparam int DRAIN_CYCLES  = 40;
	localparam int LONG_HOLD     = 300;
	localparam int STALL_PHASE   = 2;

	localparam int FILTER_TAPS [KERNEL_COUNT][3][3] = '{
		'{'{ 0, -1,  0}, '{-1,  5,  1}, '{ 0, -1,  0}},
		'{'{ 0,  0,  0}, '{-1,  1,  0}, '{ 0,  0,  0}},
		'{'{ 0,  1,  0}, '{ 1, -4,  1}, '{ 0,  1,  0}},
		'{'{-1,  0,  1}, '{-2,  0,  2}, '{-1,  0,  1}},
		'{'{ 1, -2,  1}, '{-2,  5, -2}, '{ 1, -2,  1}}
	};

	localparam int KERNEL_SEQ [PHASE_COUNT] = '{0, 3, 7, 1, 5, 2, 6, 4};

	typedef struct {
		c3wfk_pkg::kind_t     kind;
		logic [COORD_W-1:0]   row;
		logic [COORD_W-1:0]   col;
		logic [PIXEL_W-1:0]   pixel;
	} pixel_op_t;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic [COORD_W-1:0]        row;
		logic [COORD_W-1:0]        col;
	} conv_result_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	c3wfk_req_if req_ch();
	c3wfk_rsp_if rsp_ch();

	conv3x3_wrap_fixed_kernels_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #10 clk = ~clk;

	// stimulus side
	pixel_op_t    pending_ops[$];
	bit           loaded [bit [19:0]];
	bit [19:0]    centres[$];
	int           ops_made;

	// prediction side
	logic [PIXEL_W-1:0] frame_px [bit [19:0]];
	logic [SEL_W-1:0]   active_kernel;
	conv_result_t       expected_sums[$];

	int mismatches;
	int cycle_count;
	int phase_no;
	int send_idle_pct;
	int recv_idle_pct;
	int send_gap;
	int recv_gap;
	int hold_left;
	bit hold_done;

	function automatic void flag_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%s", msg);
		end
	endfunction

	function automatic void apply_op(pixel_op_t op);
		int                 acc;
		int                 sel;
		logic [COORD_W-1:0] rr;
		logic [COORD_W-1:0] cc;
		conv_result_t       res;
		if (op.kind == c3wfk_pkg::KIND_LOAD) begin
			frame_px[{op.row, op.col}] = op.pixel;
		end else begin
			acc = 0;
			sel = (active_kernel > SEL_W'(KERNEL_COUNT - 1)) ? KERNEL_COUNT - 1 : int'(active_kernel);
			for (int a = 0; a < 3; a++) begin
				for (int b = 0; b < 3; b++) begin
					rr = op.row + COORD_W'(a) - 10'd1;
					cc = op.col + COORD_W'(b) - 10'd1;
					if (frame_px.exists({rr, cc})) begin
						acc += int'(frame_px[{rr, cc}]) * FILTER_TAPS[sel][a][b];
					end
				end
			end
			res.value = VALUE_W'(acc);
			res.row   = op.row;
			res.col   = op.col;
			expected_sums.push_back(res);
		end
	endfunction

	function automatic logic [PIXEL_W-1:0] pick_pixel();
		logic [PIXEL_W-1:0] px;
		case ($urandom_range(0, 3))
			0: px = 8'd0;
			1: px = 8'd255;
			default: px = PIXEL_W'($urandom);
		endcase
		return px;
	endfunction

	function automatic void queue_load(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
			logic [PIXEL_W-1:0] px);
		pixel_op_t op;
		op = '{c3wfk_pkg::KIND_LOAD, r, c, px};
		pending_ops.push_back(op);
		loaded[{r, c}] = 1'b1;
		ops_made++;
	endfunction

	function automatic void queue_compute(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
		pixel_op_t op;
		op = '{c3wfk_pkg::KIND_COMPUTE, r, c, PIXEL_W'($urandom)};
		pending_ops.push_back(op);
		ops_made++;
	endfunction

	function automatic bit window_loaded(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
		bit ok;
		ok = 1'b1;
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				if (!loaded.exists({r + COORD_W'(a) - 10'd1, c + COORD_W'(b) - 10'd1})) begin
					ok = 1'b0;
				end
			end
		end
		return ok;
	endfunction

	// corners and centre one extreme, edge neighbours the other
	function automatic void load_checkerboard(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
			bit invert);
		bit high;
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				high = ((a + b) % 2 == 0) ^ invert;
				queue_load(r + COORD_W'(a) - 10'd1, c + COORD_W'(b) - 10'd1,
					high ? 8'd255 : 8'd0);
			end
		end
	endfunction

	function automatic void random_step();
		int                 choice;
		bit [19:0]          base;
		logic [COORD_W-1:0] r;
		logic [COORD_W-1:0] c;
		choice = $urandom_range(0, 99);
		base = centres[$urandom_range(0, centres.size() - 1)];
		if (choice < 35) begin
			if ($urandom_range(0, 1)) begin
				r = COORD_W'($urandom);
				c = COORD_W'($urandom);
			end else begin
				r = base[19:10] + COORD_W'($urandom_range(0, 4)) - 10'd2;
				c = base[9:0] + COORD_W'($urandom_range(0, 4)) - 10'd2;
			end
			for (int a = 0; a < 3; a++) begin
				for (int b = 0; b < 3; b++) begin
					if (!loaded.exists({r + COORD_W'(a) - 10'd1, c + COORD_W'(b) - 10'd1})
							|| $urandom_range(0, 2) == 0) begin
						queue_load(r + COORD_W'(a) - 10'd1, c + COORD_W'(b) - 10'd1,
							pick_pixel());
					end
				end
			end
			queue_compute(r, c);
			centres.push_back({r, c});
		end else if (choice < 60) begin
			queue_compute(base[19:10], base[9:0]);
		end else if (choice < 70) begin
			r = base[19:10] + COORD_W'($urandom_range(0, 2)) - 10'd1;
			c = base[9:0] + COORD_W'($urandom_range(0, 2)) - 10'd1;
			if (window_loaded(r, c)) begin
				queue_compute(r, c);
			end
		end else if (choice < 90) begin
			r = base[19:10] + COORD_W'($urandom_range(0, 2)) - 10'd1;
			c = base[9:0] + COORD_W'($urandom_range(0, 2)) - 10'd1;
			queue_load(r, c, pick_pixel());
		end else begin
			queue_load(COORD_W'($urandom), COORD_W'($urandom), pick_pixel());
		end
	endfunction

	task automatic apb_access(input bit wr, input logic [CFG_ADDR_W-1:0] addr,
			input logic [CFG_DATA_W-1:0] wdata, output logic [CFG_DATA_W-1:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.kind  <= c3wfk_pkg::KIND_LOAD;
			req_ch.row   <= '0;
			req_ch.col   <= '0;
			req_ch.pixel <= '0;
			send_gap = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				apply_op('{c3wfk_pkg::kind_t'(req_ch.kind), req_ch.row, req_ch.col,
					req_ch.pixel});
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (pending_ops.size() != 0
						&& $urandom_range(0, 99) < send_idle_pct) begin
					send_gap = $urandom_range(0, 4);
					req_ch.valid <= 1'b0;
				end else if (pending_ops.size() != 0) begin
					pixel_op_t op;
					op = pending_ops.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.kind  <= op.kind;
					req_ch.row   <= op.row;
					req_ch.col   <= op.col;
					req_ch.pixel <= op.pixel;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_sums.size() == 0) begin
					flag_mismatch($sformatf("unexpected transaction: value %0d row %0d col %0d",
						rsp_ch.value, rsp_ch.out_row, rsp_ch.out_col));
				end else begin
					conv_result_t exp_res;
					exp_res = expected_sums.pop_front();
					if (rsp_ch.value !== exp_res.value || rsp_ch.out_row !== exp_res.row
							|| rsp_ch.out_col !== exp_res.col) begin
						flag_mismatch($sformatf(
							"mismatch: expected value %0d row %0d col %0d, got %0d %0d %0d",
							exp_res.value, exp_res.row, exp_res.col,
							rsp_ch.value, rsp_ch.out_row, rsp_ch.out_col));
					end
				end
			end
			// back-pressure long enough to fill the block
			if (!hold_done && phase_no == STALL_PHASE && rsp_ch.valid) begin
				hold_left = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				rsp_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < recv_idle_pct) begin
				recv_gap = $urandom_range(0, 4);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0] rd;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		active_kernel = '0;
		mismatches    = 0;
		cycle_count   = 0;
		phase_no      = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left     = 0;
		hold_done     = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < PHASE_COUNT; p++) begin
			phase_no = p;
			if (p == PHASE_COUNT - 1) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else begin
				send_idle_pct = 10 * $urandom_range(0, 3);
				recv_idle_pct = 10 * $urandom_range(0, 3);
			end
			apb_access(1'b1, {c3wfk_pkg::REG_KERNEL_SELECT, 2'b00},
				CFG_DATA_W'(KERNEL_SEQ[p]), rd);
			active_kernel = SEL_W'(KERNEL_SEQ[p]);
			apb_access(1'b0, {c3wfk_pkg::REG_KERNEL_SELECT, 2'b00}, '0, rd);
			if (rd[SEL_W-1:0] !== active_kernel) begin
				flag_mismatch($sformatf("kernel_select read back %0d, expected %0d",
					rd[SEL_W-1:0], active_kernel));
			end

			ops_made = 0;
			if (p == 0) begin
				// wrap windows at the origin and at the far edge, with opposite checkerboards
				load_checkerboard(10'd0, 10'd0, 1'b0);
				load_checkerboard(10'd512, 10'd1023, 1'b1);
				centres.push_back({10'd0, 10'd0});
				centres.push_back({10'd512, 10'd1023});
			end
			queue_compute(10'd0, 10'd0);
			queue_compute(10'd512, 10'd1023);
			while (ops_made < PHASE_OPS) begin
				random_step();
			end

			while (pending_ops.size() != 0 || req_ch.valid || expected_sums.size() != 0) begin
				@(posedge clk);
			end
			repeat (DRAIN_CYCLES) @(posedge clk);
		end

		if (expected_sums.size() != 0) begin
			flag_mismatch($sformatf("%0d results never arrived", expected_sums.size()));
		end
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
